/* rtl/clcd_pkg.sv */
// Shared types and constants for the character LCD dirty-refresh engine.
// Used by every other file of the block except clcd_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

	// Default screen geometry
	localparam int DEF_COLUMNS = 8;
	localparam int DEF_ROWS    = 2;

	// Field widths fixed by the item format
	localparam int BYTE_W  = 8;
	localparam int MASK_W  = 8;
	localparam int COL_W   = 3;
	localparam int KIND_W  = 2;
	localparam int MAP_DEPTH = 256;
	localparam int QUEUE_DEPTH = 2;

	// LCD bus codes
	localparam logic [BYTE_W-1:0] LCD_DDRAM     = 8'h80;
	localparam int                LCD_ROW_SHIFT = 6;
	localparam logic [BYTE_W-1:0] LCD_CLEAR     = 8'h01;
	localparam logic [MASK_W-1:0] ALL_DIRTY     = 8'hff;

	// Register select values
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// Item kinds as they arrive on the input channel
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REFRESH = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd3;

	// Operations handed from the front end to the executor
	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_REFRESH = 2'd2,
		OP_LOAD    = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [COL_W-1:0]  column;
		logic              row;
		logic [BYTE_W-1:0] char_code;
		logic [BYTE_W-1:0] map_value;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/clcd_if.sv */
// Valid/ready channel interfaces for the item input and the LCD bus output.
// Depends on clcd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface clcd_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [clcd_pkg::KIND_W-1:0]  kind;
	logic [clcd_pkg::COL_W-1:0]   column;
	logic                         row;
	logic [clcd_pkg::BYTE_W-1:0]  char_code;
	logic [clcd_pkg::BYTE_W-1:0]  map_value;

	modport source (output valid, kind, column, row, char_code, map_value, input ready);
	modport sink   (input valid, kind, column, row, char_code, map_value, output ready);
endinterface

interface clcd_bus_if;
	logic                         valid;
	logic                         ready;
	logic                         register_select;
	logic [clcd_pkg::BYTE_W-1:0]  bus_byte;
	logic                         last;

	modport source (output valid, register_select, bus_byte, last, input ready);
	modport sink   (input valid, register_select, bus_byte, last, output ready);
endinterface

`default_nettype wire

/* rtl/clcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module clcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/clcd_fifo.sv */
// Short command queue between the front end and the executor.
// Depends on clcd_pkg for the command type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module clcd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  clcd_pkg::cmd_t     push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output clcd_pkg::cmd_t     pop_data
);
	import clcd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/clcd_front.sv */
// Front end: takes item transfers, drops out-of-range cell writes and
// decodes the kind into an executor operation. Depends on clcd_pkg, clcd_if.
`timescale 1ns / 1ps
`default_nettype none

module clcd_front #(
	parameter int COLUMNS = clcd_pkg::DEF_COLUMNS,
	parameter int ROWS    = clcd_pkg::DEF_ROWS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	clcd_cmd_if.sink        cmd,
	output logic            push,
	output clcd_pkg::cmd_t  push_data,
	input  wire logic       full
);
	import clcd_pkg::*;

	logic v_s1;
	cmd_t cmd_s1;
	logic take;
	logic in_range;
	op_t  op_dec;

	assign push      = v_s1 && !full;
	assign push_data = cmd_s1;
	assign cmd.ready = !v_s1 || !full;
	assign take      = cmd.valid && cmd.ready;

	// Cell bounds check against the configured geometry
	assign in_range = (int'(cmd.column) < COLUMNS) && (int'(cmd.row) < ROWS);

	// Kind decode
	always_comb begin
		case (cmd.kind)
			KIND_WRITE:   op_dec = OP_WRITE;
			KIND_CLEAR:   op_dec = OP_CLEAR;
			KIND_REFRESH: op_dec = OP_REFRESH;
			KIND_LOAD:    op_dec = OP_LOAD;
			default:      op_dec = OP_LOAD;
		endcase
	end

	// Decode stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= !((op_dec == OP_WRITE) && !in_range);
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op        <= op_dec;
			cmd_s1.column    <= cmd.column;
			cmd_s1.row       <= cmd.row;
			cmd_s1.char_code <= cmd.char_code;
			cmd_s1.map_value <= cmd.map_value;
		end
	end

endmodule

`default_nettype wire

/* rtl/clcd_back.sv */
// Executor: owns the shadow cell store, dirty masks and the translation RAM,
// runs one queued operation at a time and drives the LCD bus channel.
// Depends on clcd_pkg, clcd_if and clcd_ram.
`timescale 1ns / 1ps
`default_nettype none

module clcd_back #(
	parameter int COLUMNS = clcd_pkg::DEF_COLUMNS,
	parameter int ROWS    = clcd_pkg::DEF_ROWS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       powered,
	input  wire logic       q_valid,
	input  clcd_pkg::cmd_t  q_data,
	output logic            pop,
	clcd_bus_if.source      bus
);
	import clcd_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [MASK_W-1:0] COL_MASK = MASK_W'((1 << COLUMNS) - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROW  = 4'b0010,
		ST_ADDR = 4'b0100,
		ST_DATA = 4'b1000
	} state_t;

	state_t            state_q;
	logic [BYTE_W-1:0] cell_q  [CELLS];
	logic [MASK_W-1:0] dirty_q [ROWS];
	logic [MASK_W-1:0] work_q;
	logic              row_q;
	logic              last_pend_q;

	logic              out_v_q;
	logic              out_rs_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              out_free;
	logic              out_load;
	logic [CELL_W-1:0] wr_idx;
	logic [CELL_W-1:0] scan_idx;
	logic [COL_W-1:0]  low_col;
	logic [MASK_W-1:0] low_bit;
	logic [MASK_W-1:0] row_mask;
	logic              later_dirty;
	logic              more_rows;
	logic              ram_we;
	logic              ram_re;
	logic [BYTE_W-1:0] ram_rdata;

	assign bus.valid           = out_v_q;
	assign bus.register_select = out_rs_q;
	assign bus.bus_byte        = out_byte_q;
	assign bus.last            = out_last_q;

	assign out_free = !out_v_q || bus.ready;
	assign pop      = (state_q == ST_IDLE) && q_valid && out_free;

	// Output register takes a new byte this cycle
	assign out_load = (pop && (q_data.op == OP_CLEAR) && powered)
		|| (((state_q == ST_ADDR) || (state_q == ST_DATA)) && out_free);

	// Cell indexes, row-major
	assign wr_idx   = CELL_W'(int'(q_data.row) * COLUMNS + int'(q_data.column));
	assign scan_idx = CELL_W'(int'(row_q) * COLUMNS + int'(low_col));

	assign row_mask  = dirty_q[row_q] & COL_MASK;
	assign more_rows = (int'(row_q) + 1) < ROWS;

	// Lowest pending column of the row being sent
	always_comb begin
		low_col = '0;
		for (int c = MASK_W - 1; c >= 0; c--) begin
			if (work_q[c]) begin
				low_col = COL_W'(c);
			end
		end
		low_bit = MASK_W'(1) << low_col;
	end

	// Any sendable cell left in a row after the current one
	always_comb begin
		later_dirty = 1'b0;
		for (int r = 0; r < ROWS; r++) begin
			if ((r > int'(row_q)) && ((dirty_q[r] & COL_MASK) != '0)) begin
				later_dirty = 1'b1;
			end
		end
	end

	// Translation table
	assign ram_we = pop && (q_data.op == OP_LOAD);
	assign ram_re = (state_q == ST_ADDR) && out_free;

	clcd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (q_data.char_code),
		.wdata (q_data.map_value),
		.re    (ram_re),
		.raddr (cell_q[scan_idx]),
		.rdata (ram_rdata)
	);

	// Sequencer, shadow state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			work_q      <= '0;
			row_q       <= 1'b0;
			last_pend_q <= 1'b0;
			out_v_q     <= 1'b0;
			out_rs_q    <= RS_CMD;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			for (int i = 0; i < CELLS; i++) begin
				cell_q[i] <= '0;
			end
			for (int r = 0; r < ROWS; r++) begin
				dirty_q[r] <= '0;
			end
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (bus.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (q_data.op)
							OP_WRITE: begin
								if (cell_q[wr_idx] != q_data.char_code) begin
									cell_q[wr_idx] <= q_data.char_code;
									dirty_q[q_data.row][q_data.column] <= 1'b1;
								end
							end
							OP_CLEAR: begin
								for (int i = 0; i < CELLS; i++) begin
									cell_q[i] <= '0;
								end
								for (int r = 0; r < ROWS; r++) begin
									dirty_q[r] <= ALL_DIRTY;
								end
								if (powered) begin
									out_rs_q   <= RS_CMD;
									out_byte_q <= LCD_CLEAR;
									out_last_q <= 1'b1;
								end
							end
							OP_REFRESH: begin
								if (powered) begin
									row_q   <= 1'b0;
									state_q <= ST_ROW;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ROW: begin
					// Latch the row's sendable marks and clear the whole mask
					work_q         <= row_mask;
					dirty_q[row_q] <= '0;
					if (row_mask != '0) begin
						state_q <= ST_ADDR;
					end else if (more_rows) begin
						row_q <= row_q + 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ADDR: begin
					if (out_free) begin
						out_rs_q    <= RS_CMD;
						out_byte_q  <= LCD_DDRAM | (BYTE_W'(row_q) << LCD_ROW_SHIFT)
							| BYTE_W'(low_col);
						out_last_q  <= 1'b0;
						work_q      <= work_q & ~low_bit;
						last_pend_q <= ((work_q & ~low_bit) == '0) && !later_dirty;
						state_q     <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (out_free) begin
						out_rs_q   <= RS_DATA;
						out_byte_q <= ram_rdata;
						out_last_q <= last_pend_q;
						if (work_q != '0) begin
							state_q <= ST_ADDR;
						end else if (more_rows) begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_ROW;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/char_lcd_dirty_refresh_top.sv */
// Top level of the character LCD dirty-refresh engine: front end, command
// queue, executor and the power register. Depends on clcd_pkg, clcd_if,
// clcd_front, clcd_fifo and clcd_back.
`timescale 1ns / 1ps
`default_nettype none

// Items enter through a decode stage and a two-entry queue, so the input
// keeps taking transfers while the executor is busy or the bus is stalled,
// until both are full. The executor runs one operation at a time: a cell
// write, translation load or clear is done at dispatch (a clear also sends
// one command byte when powered); a powered refresh visits each row and
// sends two bytes per dirty cell, the DDRAM address byte and then the
// translated data byte, in turn through the single bus output register and
// the one read port of the translation RAM. The translation table must be
// loaded for every code a refresh will send; entries are not cleared by reset.
// display_powered (powered_q) is written through cfg_we/cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
module char_lcd_dirty_refresh_top #(
	parameter int COLUMNS = clcd_pkg::DEF_COLUMNS,
	parameter int ROWS    = clcd_pkg::DEF_ROWS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	clcd_cmd_if.sink   cmd,
	clcd_bus_if.source bus,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata
);
	import clcd_pkg::*;

	logic powered_q;
	logic push;
	cmd_t push_data;
	logic full;
	logic pop;
	logic not_empty;
	cmd_t pop_data;

	// Display power register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			powered_q <= 1'b0;
		end else if (cfg_we) begin
			powered_q <= cfg_wdata;
		end
	end

	clcd_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	clcd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	clcd_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.powered (powered_q),
		.q_valid (not_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.bus     (bus)
	);

endmodule

`default_nettype wire
